[hdl/lcc_pkg.sv]
// Shared types and constants for the 16-bit instruction-step core.
// Holds the opcode and event codes and the execute result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

  // Main memory geometry (MEM_WORDS is a power of two)
  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_WORDS - 1);

  // Host operation codes
  localparam logic [1:0] OPER_WRITE = 2'd0;
  localparam logic [1:0] OPER_EXEC  = 2'd1;
  localparam logic [1:0] OPER_READ  = 2'd2;

  // Result event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_NEWLINE = 2'd1;
  localparam logic [1:0] EV_PRINT   = 2'd2;
  localparam logic [1:0] EV_READ    = 2'd3;

  // Trap vectors
  localparam logic [4:0] TRAP_HALT    = 5'h00;
  localparam logic [4:0] TRAP_NEWLINE = 5'h01;
  localparam logic [4:0] TRAP_PRINT   = 5'h02;

  // Flag bit positions
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  // Link register of bl/blr
  localparam logic [2:0] LINK_REG = 3'd7;

  // Instruction opcodes (ir[15:12]); unlisted codes are no-ops
  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LD   = 4'd2,
    OP_ST   = 4'd3,
    OP_BL   = 4'd4,
    OP_AND  = 4'd5,
    OP_LDR  = 4'd6,
    OP_STR  = 4'd7,
    OP_NOT  = 4'd9,
    OP_JMP  = 4'd12,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } op_e;

  // Everything one instruction decides in its execute cycle
  typedef struct packed {
    logic [15:0] pc;
    logic [3:0]  flags;
    logic        halt;
    logic [1:0]  ev;
    logic [15:0] value;
    logic        rf_we;
    logic [2:0]  rf_waddr;
    logic [15:0] rf_wdata;
    logic        mem_rd;
    logic        mem_wr;
    logic [15:0] mem_addr;
    logic [15:0] mem_wdata;
  } exec_res_t;

  // Second register read port carries dr for stores and print, sr2 otherwise
  function automatic logic [2:0] port_b_addr(logic [15:0] ir);
    logic [3:0] op;
    op = ir[15:12];
    if (op == OP_ST || op == OP_STR || op == OP_TRAP) begin
      return ir[11:9];
    end
    return ir[2:0];
  endfunction

endpackage

`default_nettype wire

[hdl/lcc_cpu_instruction_step_core.sv]
// Top level of the 16-bit instruction-step core: sequencer, state registers
// and output register. Uses lcc_pkg, lcc_mem, lcc_regfile and lcc_exec.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer writes a memory word, reads one, or executes the
// instruction at pc; each produces exactly one result transfer. All work
// goes through a single-port main memory with registered reads. An execute
// item steps through fetch, register read and execute; a load adds a
// write-back step, as its data access takes the memory port a second time;
// a host read or write goes through a response step. The next item is
// taken in the cycle an item finishes whenever the result register and the
// memory port are free in that cycle. After reset it zeroes all MEM_WORDS
// words (65536 by default), one per cycle, taking no input during the sweep.
module lcc_cpu_instruction_step_core
  import lcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               halted_o,
  output logic [1:0]         event_res_o,
  output logic signed [15:0] value_o,
  output logic [15:0]        next_pc_o,
  output logic [3:0]         flags_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP,
    ST_RDATA,
    ST_FETCH,
    ST_EXEC,
    ST_LDWB
  } state_e;

  state_e              state_q, state_d, acc_state;
  logic [MEM_AW-1:0]   clr_cnt_q;
  logic [15:0]         pc_q;
  logic [3:0]          flags_q;
  logic                halt_q;
  logic [2:0]          ld_dst_q;

  logic                out_valid_q;
  logic                out_halt_q, out_halt_d;
  logic [1:0]          out_ev_q, out_ev_d;
  logic [15:0]         out_val_q, out_val_d;
  logic [15:0]         out_pc_q, out_pc_d;
  logic [3:0]          out_flags_q, out_flags_d;
  logic                out_load;

  logic                out_free;
  logic                in_acc;
  logic                exec_mem;
  logic                exec_go;
  logic                exec_upd;
  logic [15:0]         pc_now;
  logic                halt_now;

  logic                mem_we;
  logic                mem_re;
  logic [MEM_AW-1:0]   mem_addr;
  logic [15:0]         mem_wdata;
  logic [15:0]         mem_rdata;

  logic                rf_we;
  logic [2:0]          rf_waddr;
  logic [15:0]         rf_wdata;
  logic [15:0]         rs1;
  logic [15:0]         rsb;

  exec_res_t           res;

  lcc_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Register addresses come straight from the fetched word
  lcc_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (state_q == ST_FETCH),
    .raddr_a_i (mem_rdata[8:6]),
    .raddr_b_i (port_b_addr(mem_rdata)),
    .rdata_a_o (rs1),
    .rdata_b_o (rsb),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata)
  );

  // Memory read data holds the instruction throughout the execute cycle
  lcc_exec u_exec (
    .ir_i    (mem_rdata),
    .pc_i    (pc_q),
    .flags_i (flags_q),
    .rs1_i   (rs1),
    .rsb_i   (rsb),
    .res_o   (res)
  );

  // Finish states take a new item when the output and memory port are free
  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    exec_mem = res.mem_rd || res.mem_wr;
    exec_go  = res.mem_rd || out_free;
    unique case (state_q)
      ST_IDLE:                     in_ready_o = 1'b1;
      ST_RESP, ST_RDATA, ST_LDWB:  in_ready_o = out_free;
      ST_EXEC:                     in_ready_o = out_free && !exec_mem;
      default:                     in_ready_o = 1'b0;
    endcase
    in_acc = in_valid_i && in_ready_o;

    // pc and halt as they stand after this cycle
    pc_now   = (state_q == ST_EXEC) ? res.pc : pc_q;
    halt_now = halt_q || ((state_q == ST_EXEC) && res.halt);

    unique case (operation_i)
      OPER_READ: acc_state = ST_RDATA;
      OPER_EXEC: acc_state = halt_now ? ST_RESP : ST_FETCH;
      default:   acc_state = ST_RESP;
    endcase
  end

  // Memory port arbitration
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = address_i[MEM_AW-1:0];
    mem_wdata = data_i;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_q;
      mem_wdata = '0;
    end else if ((state_q == ST_EXEC) && exec_go && exec_mem) begin
      mem_re    = res.mem_rd;
      mem_we    = res.mem_wr;
      mem_addr  = res.mem_addr[MEM_AW-1:0];
      mem_wdata = res.mem_wdata;
    end else if (in_acc) begin
      unique case (operation_i)
        OPER_WRITE: mem_we = 1'b1;
        OPER_READ:  mem_re = 1'b1;
        OPER_EXEC: begin
          mem_re   = !halt_now;
          mem_addr = pc_now[MEM_AW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Sequencer next state, register write-back and result capture
  always_comb begin
    state_d     = state_q;
    out_load    = 1'b0;
    out_halt_d  = halt_q;
    out_ev_d    = EV_NONE;
    out_val_d   = '0;
    out_pc_d    = pc_q;
    out_flags_d = flags_q;
    exec_upd    = 1'b0;
    rf_we       = 1'b0;
    rf_waddr    = res.rf_waddr;
    rf_wdata    = res.rf_wdata;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = acc_state;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = in_acc ? acc_state : ST_IDLE;
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_ev_d  = EV_READ;
          out_val_d = mem_rdata;
          state_d   = in_acc ? acc_state : ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) begin
          exec_upd = 1'b1;
          rf_we    = res.rf_we;
          if (res.mem_rd) begin
            state_d = ST_LDWB;
          end else begin
            out_load    = 1'b1;
            out_halt_d  = halt_now;
            out_ev_d    = res.ev;
            out_val_d   = res.value;
            out_pc_d    = res.pc;
            out_flags_d = res.flags;
            state_d     = in_acc ? acc_state : ST_IDLE;
          end
        end
      end
      ST_LDWB: begin
        if (out_free) begin
          rf_we    = 1'b1;
          rf_waddr = ld_dst_q;
          rf_wdata = mem_rdata;
          out_load = 1'b1;
          state_d  = in_acc ? acc_state : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      pc_q        <= '0;
      flags_q     <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
      end
      if (exec_upd) begin
        pc_q    <= res.pc;
        flags_q <= res.flags;
        halt_q  <= halt_now;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (exec_upd) begin
      ld_dst_q <= res.rf_waddr;
    end
    if (out_load) begin
      out_halt_q  <= out_halt_d;
      out_ev_q    <= out_ev_d;
      out_val_q   <= out_val_d;
      out_pc_q    <= out_pc_d;
      out_flags_q <= out_flags_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign halted_o    = out_halt_q;
  assign event_res_o = out_ev_q;
  assign value_o     = out_val_q;
  assign next_pc_o   = out_pc_q;
  assign flags_o     = out_flags_q;

endmodule

`default_nettype wire

[hdl/lcc_mem.sv]
// Main word memory: single port, synchronous registered read.
// Depends on lcc_pkg for the depth.
`timescale 1ns / 1ps
`default_nettype none

module lcc_mem
  import lcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [MEM_AW-1:0] addr_i,
  input  logic [15:0]       wdata_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rdata_q;

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/lcc_regfile.sv]
// Eight-entry register file: two synchronous read ports, one write port.
// Valid bits make never-written registers read as zero. Uses lcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcc_regfile
  import lcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        re_i,
  input  logic [2:0]  raddr_a_i,
  input  logic [2:0]  raddr_b_i,
  output logic [15:0] rdata_a_o,
  output logic [15:0] rdata_b_o,
  input  logic        we_i,
  input  logic [2:0]  waddr_i,
  input  logic [15:0] wdata_i
);

  logic [15:0] regs [8];
  logic [7:0]  valid_q;
  logic [15:0] rdata_a_q;
  logic [15:0] rdata_b_q;

  // Valid bits: cleared by reset, set on first write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Storage and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      regs[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= valid_q[raddr_a_i] ? regs[raddr_a_i] : '0;
      rdata_b_q <= valid_q[raddr_b_i] ? regs[raddr_b_i] : '0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[hdl/lcc_exec.sv]
// Instruction execute logic: decode, ALU, branch test, address generation.
// Purely combinational; depends on lcc_pkg for opcodes and exec_res_t.
`timescale 1ns / 1ps
`default_nettype none

module lcc_exec
  import lcc_pkg::*;
(
  input  logic [15:0] ir_i,
  input  logic [15:0] pc_i,
  input  logic [3:0]  flags_i,
  input  logic [15:0] rs1_i,
  input  logic [15:0] rsb_i,
  output exec_res_t   res_o
);

  // Branch condition field
  typedef enum logic [2:0] {
    CC_EQ    = 3'd0,
    CC_NE    = 3'd1,
    CC_MI    = 3'd2,
    CC_NZ_EQ = 3'd3,
    CC_LT    = 3'd4,
    CC_GT    = 3'd5,
    CC_CS    = 3'd6,
    CC_AL    = 3'd7
  } cc_e;

  logic [15:0] pc_inc;
  logic [15:0] off9;
  logic [15:0] off11;
  logic [15:0] off6;
  logic [15:0] imm5;
  logic [15:0] op2;
  logic [15:0] base;
  logic [16:0] sum;
  logic [15:0] and_res;
  logic [15:0] not_res;
  logic        n;
  logic        z;
  logic        c;
  logic        v;
  logic        taken;
  logic        add_v;

  always_comb begin
    pc_inc  = pc_i + 16'd1;
    off9    = {{7{ir_i[8]}}, ir_i[8:0]};
    off11   = {{5{ir_i[10]}}, ir_i[10:0]};
    off6    = {{10{ir_i[5]}}, ir_i[5:0]};
    imm5    = {{11{ir_i[4]}}, ir_i[4:0]};
    op2     = ir_i[5] ? imm5 : rsb_i;
    sum     = {1'b0, rs1_i} + {1'b0, op2};
    add_v   = ~(rs1_i[15] ^ op2[15]) & (rs1_i[15] ^ sum[15]);
    and_res = rs1_i & op2;
    not_res = ~rs1_i;
    // blr through r7 sees the link value already written
    base    = (ir_i[8:6] == LINK_REG) ? pc_inc : rs1_i;

    n = flags_i[FLAG_N];
    z = flags_i[FLAG_Z];
    c = flags_i[FLAG_C];
    v = flags_i[FLAG_V];
    unique case (cc_e'(ir_i[11:9]))
      CC_EQ:    taken = z;
      CC_NE:    taken = !z;
      CC_MI:    taken = n;
      CC_NZ_EQ: taken = (n == z);
      CC_LT:    taken = (n != v);
      CC_GT:    taken = (n == v) && !z;
      CC_CS:    taken = c;
      CC_AL:    taken = 1'b1;
    endcase
  end

  always_comb begin
    res_o           = '0;
    res_o.pc        = pc_inc;
    res_o.flags     = flags_i;
    res_o.ev        = EV_NONE;
    res_o.rf_waddr  = ir_i[11:9];
    res_o.mem_addr  = pc_inc + off9;
    res_o.mem_wdata = rsb_i;

    unique case (op_e'(ir_i[15:12]))
      OP_BR: begin
        if (taken) begin
          res_o.pc = pc_inc + off9;
        end
      end
      OP_ADD: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = sum[15:0];
        res_o.flags    = {sum[15], sum[15:0] == 16'd0, sum[16], add_v};
      end
      OP_LD: begin
        res_o.mem_rd = 1'b1;
      end
      OP_ST: begin
        res_o.mem_wr = 1'b1;
      end
      OP_BL: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_waddr = LINK_REG;
        res_o.rf_wdata = pc_inc;
        res_o.pc       = ir_i[11] ? (pc_inc + off11) : (base + off6);
      end
      OP_AND: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = and_res;
        res_o.flags    = {and_res[15], and_res == 16'd0, flags_i[FLAG_C], flags_i[FLAG_V]};
      end
      OP_LDR: begin
        res_o.mem_rd   = 1'b1;
        res_o.mem_addr = rs1_i + off6;
      end
      OP_STR: begin
        res_o.mem_wr   = 1'b1;
        res_o.mem_addr = rs1_i + off6;
      end
      OP_NOT: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = not_res;
        res_o.flags    = {not_res[15], not_res == 16'd0, flags_i[FLAG_C], flags_i[FLAG_V]};
      end
      OP_JMP: begin
        res_o.pc = rs1_i + off6;
      end
      OP_LEA: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = pc_inc + off9;
      end
      OP_TRAP: begin
        unique case (ir_i[4:0])
          TRAP_HALT:    res_o.halt = 1'b1;
          TRAP_NEWLINE: res_o.ev   = EV_NEWLINE;
          TRAP_PRINT: begin
            res_o.ev    = EV_PRINT;
            res_o.value = rsb_i;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/lcc_checker.sv]
// Port-level checks for the instruction-step core, bound to the top level.
// Depends on lcc_pkg for event codes.
`timescale 1ns / 1ps
`default_nettype none

module lcc_checker
  import lcc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        halted_o,
  input wire logic [1:0]  event_res_o,
  input wire logic [15:0] value_o
);

  logic [1:0] pend_q;
  logic       seen_halt_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Items accepted but not yet delivered, and sticky halt seen on results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      seen_halt_q <= 1'b0;
    end else begin
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
      if (out_xfer && halted_o) begin
        seen_halt_q <= 1'b1;
      end
    end
  end

  // No result without an accepted item behind it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result shown with no item outstanding");

  // At most one item in flight plus one waiting result
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items outstanding");

  // Once halted, results stay halted and raise no trap events
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && seen_halt_q |->
      halted_o && event_res_o != EV_NEWLINE && event_res_o != EV_PRINT)
    else $error("activity after halt");

  // Events without a value carry zero
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_NONE || event_res_o == EV_NEWLINE)
      |-> value_o == 16'd0)
    else $error("nonzero value on valueless event");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o))
    else $error("stalled result changed");

endmodule

bind lcc_cpu_instruction_step_core lcc_checker u_lcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .halted_o    (halted_o),
  .event_res_o (event_res_o),
  .value_o     (value_o)
);

`default_nettype wire
